/* design/scbp_pkg.sv */
// Shared types and constants for the strided convolution, batch norm and PReLU block.
// Used by the coefficient memory, the datapath, the result FIFO and the top level.
package scbp_pkg;

  localparam int SLOTS = 11;

  localparam int SLOT_TAP0  = 0;
  localparam int SLOT_TAP1  = 1;
  localparam int SLOT_TAP2  = 2;
  localparam int SLOT_CBIAS = 3;
  localparam int SLOT_MEAN  = 4;
  localparam int SLOT_SCALE = 5;
  localparam int SLOT_GAIN  = 6;
  localparam int SLOT_NBIAS = 7;
  localparam int SLOT_SLOPE = 8;
  localparam int SLOT_AGAIN = 9;
  localparam int SLOT_ABIAS = 10;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  localparam logic REG_CONV_SHIFT = 1'b0;
  localparam logic REG_NORM_SHIFT = 1'b1;

  localparam logic [4:0] SHIFT_RESET = 5'd14;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [SLOTS-1:0][31:0] coef_row_t;

  typedef struct packed {
    logic [3:0] chan;
    logic [6:0] pos;
    logic       last_chan;
    logic       row_done;
  } res_tag_t;

  typedef struct packed {
    res_tag_t           tag;
    logic signed [31:0] value;
  } res_t;

endpackage

/* design/scbp_coef_mem.sv */
// Coefficient memory: one row of eleven words per output channel.
// Single word writes into a row, whole-row synchronous read. Depends on scbp_pkg.
module scbp_coef_mem
  import scbp_pkg::*;
#(
  parameter int DEPTH = 12,
  parameter int AW    = 4
) (
  input  logic        clk,
  input  logic        we,
  input  logic [AW-1:0] wr_row,
  input  logic [3:0]  wr_slot,
  input  logic [31:0] wr_data,
  input  logic        rd_en,
  input  logic [AW-1:0] rd_row,
  output coef_row_t   rd_data
);

  coef_row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_row][wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

/* design/scbp_datapath.sv */
// Pipelined channel datapath: convolution, batch norm and affine PReLU.
// Takes one channel per cycle; coefficients arrive from the memory in the cycle after issue.
// Depends on scbp_pkg.
module scbp_datapath
  import scbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               issue,
  input  res_tag_t           issue_tag,
  input  logic signed [31:0] tap_a,
  input  logic signed [31:0] tap_b,
  input  logic signed [31:0] tap_c,
  input  coef_row_t          row,
  input  logic [4:0]         conv_shift,
  input  logic [4:0]         norm_shift,
  output logic               res_valid,
  output res_t               res
);

  function automatic logic signed [65:0] rnd_const(input logic [4:0] s);
    if (s == 5'd0) begin
      return '0;
    end
    return 66'sd1 <<< (s - 5'd1);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic [8:1] v;
  res_tag_t   tag [8:1];

  // Stage 1: taps and coefficient row.
  logic signed [31:0] a1, b1, c1;
  // Stage 2: tap products.
  logic signed [47:0] p0, p1, p2;
  logic signed [31:0] cbias2, mean2, scale2, gain2, nbias2, slope2, again2, abias2;
  // Stage 3: convolution output.
  logic signed [31:0] y1;
  logic signed [31:0] mean3, scale3, gain3, nbias3, slope3, again3, abias3;
  // Stage 4: normalization product.
  logic signed [64:0] pn;
  logic signed [31:0] gain4, nbias4, slope4, again4, abias4;
  // Stage 5: normalized value.
  logic signed [31:0] xn;
  logic signed [31:0] gain5, nbias5, slope5, again5, abias5;
  // Stage 6: gain product.
  logic signed [63:0] pg;
  logic signed [31:0] nbias6, slope6, again6, abias6;
  // Stage 7: batch norm output.
  logic signed [31:0] y2;
  logic signed [31:0] slope7, again7, abias7;
  // Stage 8: PReLU products.
  logic signed [63:0] ps, pa;
  logic signed [31:0] y8, abias8;

  logic signed [15:0] t0, t1, t2;
  logic signed [65:0] rc_conv_full, rc_norm_full;
  logic signed [48:0] rc_conv;
  logic signed [48:0] s0, s1, s2;
  logic signed [50:0] acc;
  logic signed [32:0] dm;
  logic signed [65:0] xn_full;
  logic signed [64:0] g_sh;
  logic signed [64:0] m_sh, a_sh;
  logic signed [31:0] xm;
  logic signed [63:0] total;

  assign t0 = row[SLOT_TAP0][15:0];
  assign t1 = row[SLOT_TAP1][15:0];
  assign t2 = row[SLOT_TAP2][15:0];

  assign rc_conv_full = rnd_const(conv_shift);
  assign rc_norm_full = rnd_const(norm_shift);
  assign rc_conv      = rc_conv_full[48:0];

  assign s0  = (49'(p0) + rc_conv) >>> conv_shift;
  assign s1  = (49'(p1) + rc_conv) >>> conv_shift;
  assign s2  = (49'(p2) + rc_conv) >>> conv_shift;
  assign acc = 51'(s0) + 51'(s1) + 51'(s2) + 51'(cbias2);

  assign dm = 33'(y1) - 33'(mean3);

  assign xn_full = (66'(pn) + rc_norm_full) >>> norm_shift;

  assign g_sh = (65'(pg) + 65'sd8192) >>> 14;

  assign m_sh  = (65'(ps) + 65'sd4096) >>> 13;
  assign a_sh  = (65'(pa) + 65'sd4096) >>> 13;
  assign xm    = y8[31] ? m_sh[31:0] : y8;
  assign total = a_sh[63:0] + 64'(abias8) + 64'(xm);

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      res_valid <= 1'b0;
    end else begin
      v         <= {v[7:1], issue};
      res_valid <= v[8];
    end
  end

  always_ff @(posedge clk) begin
    tag[1] <= issue_tag;
    for (int k = 2; k <= 8; k++) begin
      tag[k] <= tag[k-1];
    end

    a1 <= tap_a;
    b1 <= tap_b;
    c1 <= tap_c;

    p0     <= 48'(a1) * 48'(t0);
    p1     <= 48'(b1) * 48'(t1);
    p2     <= 48'(c1) * 48'(t2);
    cbias2 <= row[SLOT_CBIAS];
    mean2  <= row[SLOT_MEAN];
    scale2 <= row[SLOT_SCALE];
    gain2  <= row[SLOT_GAIN];
    nbias2 <= row[SLOT_NBIAS];
    slope2 <= row[SLOT_SLOPE];
    again2 <= row[SLOT_AGAIN];
    abias2 <= row[SLOT_ABIAS];

    y1     <= sat32(64'(acc));
    mean3  <= mean2;
    scale3 <= scale2;
    gain3  <= gain2;
    nbias3 <= nbias2;
    slope3 <= slope2;
    again3 <= again2;
    abias3 <= abias2;

    pn     <= 65'(dm) * 65'(scale3);
    gain4  <= gain3;
    nbias4 <= nbias3;
    slope4 <= slope3;
    again4 <= again3;
    abias4 <= abias3;

    // Only the low word survives the normalization shift.
    xn     <= xn_full[31:0];
    gain5  <= gain4;
    nbias5 <= nbias4;
    slope5 <= slope4;
    again5 <= again4;
    abias5 <= abias4;

    pg     <= 64'(xn) * 64'(gain5);
    nbias6 <= nbias5;
    slope6 <= slope5;
    again6 <= again5;
    abias6 <= abias5;

    y2     <= sat32(g_sh[63:0] + 64'(nbias6));
    slope7 <= slope6;
    again7 <= again6;
    abias7 <= abias6;

    ps     <= 64'(y2) * 64'(slope7);
    pa     <= 64'(y2) * 64'(again7);
    y8     <= y2;
    abias8 <= abias7;

    res.tag   <= tag[8];
    res.value <= sat32(total);
  end

endmodule

/* design/scbp_res_fifo.sv */
// Result queue between the datapath and the output channel.
// Holds finished results in order while the receiver stalls. Depends on scbp_pkg.
module scbp_res_fifo
  import scbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  res_t wr_data,
  input  logic rd_en,
  output logic not_empty,
  output res_t head
);

  res_t entries [FIFO_DEPTH];

  logic [FIFO_PW-1:0] wr_ptr;
  logic [FIFO_PW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CW'(wr_en) - FIFO_CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

/* design/strided_conv_bn_prelu_fixed.sv */
// A sample that completes a position holds the input while the channel sequencer reads one
// coefficient row per cycle, pausing whenever the result queue might lack room for a result;
// coefficient writes and other samples are taken without holding the input. Results leave
// one per cycle while the receiver does not stall.
// Reset clears control, the sample window and index, and sets both shifts to 14;
// the coefficient memory is undefined until written and gets no clearing pass.
module strided_conv_bn_prelu_fixed
  import scbp_pkg::*;
#(
  parameter int IN_WIDTH     = 129,
  parameter int OUT_CHANNELS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [31:0] sample,
  input  logic [3:0]         chan_sel,
  input  logic [3:0]         coef_slot,
  input  logic signed [31:0] coef_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_chan,
  output logic [6:0]         out_pos,
  output logic signed [31:0] out_value,
  output logic               last_chan,
  output logic               row_done
);

  localparam int IDX_W = $clog2(IN_WIDTH);
  localparam int CH_W  = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } seq_state_t;

  seq_state_t state;

  logic [4:0]         conv_shift;
  logic [4:0]         norm_shift;
  logic [IDX_W-1:0]   idx;
  logic signed [31:0] win0, win1;
  logic [CH_W-1:0]    ch;
  logic [FIFO_CW-1:0] pending;
  logic signed [31:0] tap_a, tap_b, tap_c;
  logic [6:0]         pos;
  logic               last_row;

  logic               in_fire;
  logic               out_fire;
  logic               sample_fire;
  logic               mem_we;
  logic               issue;
  logic               at_last;
  logic               emit;
  logic               last_ch;
  logic [IDX_W+6:0]   pos_wide;
  logic [CH_W+3:0]    chan_sel_w;
  logic [CH_W+3:0]    ch_w;
  res_tag_t           issue_tag;
  coef_row_t          row;
  logic               res_valid;
  res_t               res;
  res_t               head;

  assign in_stall    = (state == S_RUN);
  assign in_fire     = in_valid && !in_stall;
  assign out_fire    = out_valid && !out_stall;
  assign sample_fire = in_fire && (action == ACT_SAMPLE);

  assign chan_sel_w = {{CH_W{1'b0}}, chan_sel};
  assign mem_we     = in_fire && (action == ACT_COEF)
                      && (chan_sel_w < (CH_W + 4)'(OUT_CHANNELS))
                      && (coef_slot < 4'(SLOTS));

  assign at_last  = (idx >= IDX_W'(IN_WIDTH - 1));
  assign emit     = idx[0] || at_last;
  assign pos_wide = {7'd0, idx} >> 1;

  // Results are only issued while the queue is sure to have room for them.
  assign issue   = (state == S_RUN) && (pending < FIFO_CW'(FIFO_DEPTH));
  assign last_ch = (ch == CH_W'(OUT_CHANNELS - 1));
  assign ch_w    = {4'd0, ch};

  assign issue_tag.chan      = ch_w[3:0];
  assign issue_tag.pos       = pos;
  assign issue_tag.last_chan = last_ch;
  assign issue_tag.row_done  = last_ch && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      conv_shift <= SHIFT_RESET;
      norm_shift <= SHIFT_RESET;
      idx        <= '0;
      win0       <= '0;
      win1       <= '0;
      ch         <= '0;
      pending    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CONV_SHIFT: conv_shift <= cfg_data;
          REG_NORM_SHIFT: norm_shift <= cfg_data;
          default: ;
        endcase
      end

      pending <= pending + FIFO_CW'(issue) - FIFO_CW'(out_fire);

      case (state)
        S_IDLE: begin
          if (sample_fire) begin
            if (at_last) begin
              idx  <= '0;
              win0 <= '0;
              win1 <= '0;
            end else begin
              idx  <= idx + 1'b1;
              win0 <= win1;
              win1 <= sample;
            end
            if (emit) begin
              ch    <= '0;
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (issue) begin
            ch <= ch + 1'b1;
            if (last_ch) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Taps of the position being issued; an odd-length row ends with a zero right tap.
  always_ff @(posedge clk) begin
    if (sample_fire && emit) begin
      pos      <= pos_wide[6:0];
      last_row <= at_last;
      if (idx[0]) begin
        tap_a <= win0;
        tap_b <= win1;
        tap_c <= sample;
      end else begin
        tap_a <= win1;
        tap_b <= sample;
        tap_c <= '0;
      end
    end
  end

  scbp_coef_mem #(
    .DEPTH (OUT_CHANNELS),
    .AW    (CH_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_row  (chan_sel_w[CH_W-1:0]),
    .wr_slot (coef_slot),
    .wr_data (coef_value),
    .rd_en   (issue),
    .rd_row  (ch),
    .rd_data (row)
  );

  scbp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_tag  (issue_tag),
    .tap_a      (tap_a),
    .tap_b      (tap_b),
    .tap_c      (tap_c),
    .row        (row),
    .conv_shift (conv_shift),
    .norm_shift (norm_shift),
    .res_valid  (res_valid),
    .res        (res)
  );

  scbp_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (res_valid),
    .wr_data   (res),
    .rd_en     (out_fire),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_chan  = head.tag.chan;
  assign out_pos   = head.tag.pos;
  assign out_value = head.value;
  assign last_chan = head.tag.last_chan;
  assign row_done  = head.tag.row_done;

`ifndef SYNTHESIS
  a_queue_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result queue holds an entry that was never issued");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    issue && last_ch |=> state == S_IDLE)
    else $error("sequencer kept running after the last channel");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !issue)
    else $error("coefficient write collided with a channel read");
`endif

endmodule

/* test/tb_strided_conv_bn_prelu_fixed.sv */
// Self-checking testbench for the strided convolution, batch norm and PReLU block.
// Depends on scbp_pkg and strided_conv_bn_prelu_fixed; predicts every activation and
// checks the result stream under several idling phases and a long receiver hold-off.
module tb_strided_conv_bn_prelu_fixed;
  import scbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_WIDTH     = 129;
  localparam int OUT_CHANNELS = 12;
  localparam int SETTLE       = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_NS     = 5_000_000;
  localparam int MAX_SHOWN    = 10;

  localparam longint NORM_ROUND = 8192;
  localparam int     NORM_Q     = 14;
  localparam longint AFF_ROUND  = 4096;
  localparam int     AFF_Q      = 13;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -64'sd2147483648;

  typedef struct {
    logic              action;
    logic       [31:0] sample;
    logic       [3:0]  chan_sel;
    logic       [3:0]  coef_slot;
    logic       [31:0] coef_value;
  } feed_item_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cfg_we     = 1'b0;
  logic               cfg_index  = REG_CONV_SHIFT;
  logic [4:0]         cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic               action     = ACT_SAMPLE;
  logic signed [31:0] sample     = '0;
  logic [3:0]         chan_sel   = '0;
  logic [3:0]         coef_slot  = '0;
  logic signed [31:0] coef_value = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [3:0]         out_chan;
  logic [6:0]         out_pos;
  logic signed [31:0] out_value;
  logic               last_chan;
  logic               row_done;

  logic               hold_kick  = 1'b0;
  int                 hold_left;

  // Shadow of the block: shifts, coefficient table and the sliding sample window.
  int unsigned conv_sh = SHIFT_RESET;
  int unsigned norm_sh = SHIFT_RESET;
  logic [31:0] coef_mem [OUT_CHANNELS][SLOTS];
  logic [31:0] win_old = '0;
  logic [31:0] win_new = '0;
  int unsigned row_idx = 0;

  feed_item_t  feed_q[$];
  feed_item_t  on_bus;
  res_t        expected_acts[$];
  res_t        want;
  int          queued_count   = 0;
  int          accepted_count = 0;
  int          fault_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  strided_conv_bn_prelu_fixed #(
    .IN_WIDTH    (IN_WIDTH),
    .OUT_CHANNELS(OUT_CHANNELS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .sample    (sample),
    .chan_sel  (chan_sel),
    .coef_slot (coef_slot),
    .coef_value(coef_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_chan  (out_chan),
    .out_pos   (out_pos),
    .out_value (out_value),
    .last_chan (last_chan),
    .row_done  (row_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint rnd_shr(longint v, int unsigned s);
    longint half;
    if (s == 0) return v;
    half = longint'(1) << (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint tap16(int ch, int slot);
    return longint'($signed(coef_mem[ch][slot][15:0]));
  endfunction

  function automatic longint word32(int ch, int slot);
    return sx32(coef_mem[ch][slot]);
  endfunction

  function automatic logic [31:0] channel_activation(int ch, longint a, longint b, longint c);
    longint acc, y, xn, xm, t;
    acc = rnd_shr(a * tap16(ch, SLOT_TAP0), conv_sh)
        + rnd_shr(b * tap16(ch, SLOT_TAP1), conv_sh)
        + rnd_shr(c * tap16(ch, SLOT_TAP2), conv_sh);
    y  = sat32(word32(ch, SLOT_CBIAS) + acc);
    t  = rnd_shr((y - word32(ch, SLOT_MEAN)) * word32(ch, SLOT_SCALE), norm_sh);
    xn = sx32(t[31:0]);
    y  = sat32(((xn * word32(ch, SLOT_GAIN) + NORM_ROUND) >>> NORM_Q)
               + word32(ch, SLOT_NBIAS));
    if (y < 0) begin
      t  = (y * word32(ch, SLOT_SLOPE) + AFF_ROUND) >>> AFF_Q;
      xm = sx32(t[31:0]);
    end else begin
      xm = y;
    end
    t = sat32(((y * word32(ch, SLOT_AGAIN) + AFF_ROUND) >>> AFF_Q)
              + word32(ch, SLOT_ABIAS) + xm);
    return t[31:0];
  endfunction

  // Applies one accepted transfer to the shadow state and queues the activations it causes.
  task automatic advance_row(feed_item_t it);
    bit          last, emit;
    int unsigned pos;
    longint      a, b, c;
    res_t        r;
    if (it.action == ACT_COEF) begin
      if (it.chan_sel < OUT_CHANNELS && it.coef_slot < SLOTS)
        coef_mem[it.chan_sel][it.coef_slot] = it.coef_value;
    end else begin
      last = (row_idx >= IN_WIDTH - 1);
      emit = 1'b0;
      c    = sx32(it.sample);
      a    = 0;
      b    = 0;
      pos  = 0;
      if (row_idx[0]) begin
        pos  = (row_idx - 1) / 2;
        a    = sx32(win_old);
        b    = sx32(win_new);
        emit = 1'b1;
      end else if (last) begin
        // Odd-length row: the final position sees a zero right tap.
        pos  = row_idx / 2;
        a    = sx32(win_new);
        b    = c;
        c    = 0;
        emit = 1'b1;
      end
      if (emit) begin
        for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
          r.tag.chan      = ch[3:0];
          r.tag.pos       = pos[6:0];
          r.value         = channel_activation(ch, a, b, c);
          r.tag.last_chan = (ch == OUT_CHANNELS - 1);
          r.tag.row_done  = (ch == OUT_CHANNELS - 1) && last;
          expected_acts.push_back(r);
        end
      end
      if (last) begin
        win_old = '0;
        win_new = '0;
        row_idx = 0;
      end else begin
        win_old = win_new;
        win_new = it.sample;
        row_idx = row_idx + 1;
      end
    end
  endtask

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= MAX_SHOWN) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Driver: offers the next queued item whenever the bus is free, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        advance_row(on_bus);
        accepted_count++;
      end
      if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_bus = feed_q.pop_front();
        in_valid   <= 1'b1;
        action     <= on_bus.action;
        sample     <= on_bus.sample;
        chan_sel   <= on_bus.chan_sel;
        coef_slot  <= on_bus.coef_slot;
        coef_value <= on_bus.coef_value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor: checks each result transfer against the oldest predicted activation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_acts.size() == 0) begin
          note_fault($sformatf("result with no prediction: chan %0d pos %0d value %0d",
                               out_chan, out_pos, out_value));
        end else begin
          want = expected_acts.pop_front();
          if (out_chan !== want.tag.chan || out_pos !== want.tag.pos ||
              out_value !== want.value || last_chan !== want.tag.last_chan ||
              row_done !== want.tag.row_done)
            note_fault($sformatf(
              "exp chan %0d pos %0d value %0d last %0b done %0b, got %0d %0d %0d %0b %0b",
              want.tag.chan, want.tag.pos, want.value, want.tag.last_chan,
              want.tag.row_done, out_chan, out_pos, out_value, last_chan, row_done));
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [31:0] pick_coef(int unsigned slot);
    logic [31:0] raw;
    int          span, tame;
    int unsigned r;
    raw = $urandom();
    r   = $urandom_range(15);
    if (slot <= SLOT_TAP2) span = 14;
    else if (slot == SLOT_SCALE || slot == SLOT_GAIN) span = 15;
    else if (slot == SLOT_SLOPE || slot == SLOT_AGAIN) span = 14;
    else span = 22;
    if (r == 0) return (slot <= SLOT_TAP2) ? {raw[31:16], 16'h7FFF} : 32'h7FFF_FFFF;
    if (r == 1) return (slot <= SLOT_TAP2) ? {raw[31:16], 16'h8000} : 32'h8000_0000;
    if (r == 2) return raw;
    if (r == 3) return '0;
    tame = int'($urandom_range(0, 1 << (span + 1))) - (1 << span);
    // Tap words keep random upper halves, which the block must ignore.
    return (slot <= SLOT_TAP2) ? {raw[31:16], tame[15:0]} : tame;
  endfunction

  function automatic logic [31:0] pick_sample();
    int          tame;
    int unsigned r;
    r    = $urandom_range(9);
    tame = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    case (r)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom();
      default: return tame;
    endcase
  endfunction

  task automatic push_item(logic act, logic [31:0] smp, logic [3:0] ch, logic [3:0] slot,
                           logic [31:0] val);
    feed_item_t it;
    it.action     = act;
    it.sample     = smp;
    it.chan_sel   = ch;
    it.coef_slot  = slot;
    it.coef_value = val;
    feed_q.push_back(it);
    queued_count++;
  endtask

  task automatic push_sample(logic [31:0] smp);
    push_item(ACT_SAMPLE, smp, 4'($urandom()), 4'($urandom()), $urandom());
  endtask

  task automatic push_coef(int unsigned ch, int unsigned slot, logic [31:0] val);
    push_item(ACT_COEF, $urandom(), ch[3:0], slot[3:0], val);
  endtask

  task automatic push_random(int n);
    int unsigned ch, slot;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(3) == 0) begin
          ch   = $urandom_range(15);
          slot = $urandom_range(15);
        end else begin
          ch   = $urandom_range(OUT_CHANNELS - 1);
          slot = $urandom_range(SLOTS - 1);
        end
        push_coef(ch, slot, pick_coef(slot));
      end else begin
        push_sample(pick_sample());
      end
    end
  endtask

  // Waits until every transfer is accepted and every activation has arrived, then lets
  // the pipeline settle, since a trailing coefficient write leaves nothing to wait on.
  task automatic wait_idle();
    while (accepted_count != queued_count) @(posedge clk);
    while (expected_acts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_shifts(logic [4:0] cs, logic [4:0] ns);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CONV_SHIFT;
    cfg_data  <= cs;
    @(posedge clk);
    cfg_index <= REG_NORM_SHIFT;
    cfg_data  <= ns;
    @(posedge clk);
    cfg_we    <= 1'b0;
    conv_sh = cs;
    norm_sh = ns;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Whole table first, so no sample ever reads an unwritten entry. Two channels are
    // pinned to the positive and negative extremes to drive the saturation paths.
    set_idling(0, 0);
    for (int ch = 0; ch < OUT_CHANNELS; ch++)
      for (int slot = 0; slot < SLOTS; slot++)
        if (ch == OUT_CHANNELS - 1)
          push_coef(ch, slot, (slot <= SLOT_TAP2) ? 32'h0000_7FFF : 32'h7FFF_FFFF);
        else if (ch == OUT_CHANNELS - 2)
          push_coef(ch, slot, (slot <= SLOT_TAP2) ? 32'hFFFF_8000 : 32'h8000_0000);
        else
          push_coef(ch, slot, pick_coef(slot));

    push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'h0000_0000);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h7FFF_FFFF);
    // Writes to a channel or slot that does not exist must leave the table alone.
    push_coef(12, SLOT_TAP0, 32'h1234_5678);
    push_coef(15, SLOT_CBIAS, 32'h7FFF_FFFF);
    push_coef(0, 11, 32'h8000_0000);
    push_coef(5, 15, 32'hFFFF_FFFF);
    push_coef(0, SLOT_TAP0, 32'hA5A5_7FFF);
    push_coef(0, SLOT_TAP1, 32'h5A5A_8000);
    push_coef(1, SLOT_CBIAS, 32'h7FFF_FFFF);
    push_coef(1, SLOT_SLOPE, 32'h8000_0000);
    push_sample(32'h8000_0000);
    push_sample(32'h8000_0000);
    push_sample(32'h0000_0001);
    push_sample(32'h0000_0000);
    push_sample(32'h8000_0000);
    push_sample(32'h7FFF_FFFF);
    wait_idle();

    // Zero shift means no shift and no rounding at all.
    write_shifts(5'd0, 5'd0);
    set_idling(64, 0);
    push_random(50);
    wait_idle();

    write_shifts(5'd31, 5'd31);
    set_idling(0, 64);
    push_random(50);
    wait_idle();

    write_shifts(5'd1, 5'd31);
    set_idling(7, 7);
    push_random(50);
    wait_idle();

    // The receiver holds off while the sender keeps offering, so the result buffer
    // fills and the block has to stall its input.
    write_shifts(5'd31, 5'd1);
    set_idling(0, 0);
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    push_random(50);
    wait_idle();

    write_shifts(5'($urandom_range(1, 30)), 5'($urandom_range(1, 30)));
    set_idling(0, 0);
    push_random(50);
    wait_idle();

    if (fault_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
